FILE: src/mi3_pkg.sv
// mi3_pkg: shared constants for the 3x3 matrix inverse pipeline
// element counts, cofactor operand table, quotient width
// no dependencies
package mi3_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int N_ELEM         = 9;
    localparam int N_COL          = 3;
    localparam int Q_BITS         = 96;
    // low quotient bits that must be nonzero for an element to take a negative sign
    localparam int MAG_BITS       = 64;

    // cofactor i = m[a] * m[b] - m[c] * m[d], row-major element index
    localparam int COF_IDX [N_ELEM][4] = '{
        '{4, 8, 7, 5},
        '{7, 2, 1, 8},
        '{1, 5, 4, 2},
        '{6, 5, 3, 8},
        '{0, 8, 6, 2},
        '{3, 2, 0, 5},
        '{3, 7, 6, 4},
        '{6, 1, 0, 7},
        '{0, 4, 3, 1}
    };

    // first column elements used for the determinant expansion
    localparam int COL_IDX [N_COL] = '{0, 3, 6};

endpackage

FILE: src/mi3_adj.sv
// mi3_adj: two pipeline stages forming the nine adjugate cofactors
// stage one takes the eighteen element products, stage two the differences
// depends on mi3_pkg
module mi3_adj #(
    parameter int DW = mi3_pkg::DATA_WIDTH_DEF
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_up_valid,
    output logic                                      o_up_ready,
    input  logic [mi3_pkg::N_ELEM-1:0][DW-1:0]        i_m,
    output logic                                      o_dn_valid,
    input  logic                                      i_dn_ready,
    output logic [mi3_pkg::N_ELEM-1:0][2*DW:0]        o_cof,
    output logic [mi3_pkg::N_COL-1:0][DW-1:0]         o_col
);
    import mi3_pkg::*;

    localparam int PW = 2 * DW;
    localparam int CW = 2 * DW + 1;

    logic [N_ELEM-1:0][PW-1:0] r_pa;
    logic [N_ELEM-1:0][PW-1:0] r_pb;
    logic [N_ELEM-1:0][CW-1:0] r_cof;
    logic [N_COL-1:0][DW-1:0]  r_col1;
    logic [N_COL-1:0][DW-1:0]  r_col2;
    logic                      r_v1;
    logic                      r_v2;
    logic                      w_en1;
    logic                      w_en2;

    assign w_en2 = !r_v2 || i_dn_ready;
    assign w_en1 = !r_v1 || w_en2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (w_en1) r_v1 <= i_up_valid;
            if (w_en2) r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            for (int i = 0; i < N_ELEM; i++) begin
                r_pa[i] <= PW'($signed(i_m[COF_IDX[i][0]]) * $signed(i_m[COF_IDX[i][1]]));
                r_pb[i] <= PW'($signed(i_m[COF_IDX[i][2]]) * $signed(i_m[COF_IDX[i][3]]));
            end
            for (int k = 0; k < N_COL; k++) begin
                r_col1[k] <= i_m[COL_IDX[k]];
            end
        end
        if (w_en2) begin
            for (int i = 0; i < N_ELEM; i++) begin
                r_cof[i] <= CW'($signed(r_pa[i])) - CW'($signed(r_pb[i]));
            end
            r_col2 <= r_col1;
        end
    end

    assign o_up_ready = w_en1;
    assign o_dn_valid = r_v2;
    assign o_cof      = r_cof;
    assign o_col      = r_col2;

endmodule

FILE: src/mi3_det.sv
// mi3_det: three stages for the determinant and the divider operands
// split partial products, their sum, then magnitudes and rounding offset
// depends on mi3_pkg
module mi3_det #(
    parameter int DW = mi3_pkg::DATA_WIDTH_DEF,
    parameter int FB = mi3_pkg::FRAC_BITS_DEF
) (
    input  logic                                                          i_clk,
    input  logic                                                          i_rst_n,
    input  logic                                                          i_up_valid,
    output logic                                                          o_up_ready,
    input  logic [mi3_pkg::N_ELEM-1:0][2*DW:0]                            i_cof,
    input  logic [mi3_pkg::N_COL-1:0][DW-1:0]                             i_col,
    output logic                                                          o_dn_valid,
    input  logic                                                          i_dn_ready,
    output logic [mi3_pkg::N_ELEM-1:0][3*DW+2*FB+mi3_pkg::Q_BITS+2:0]     o_num,
    output logic [3*DW+2*FB+mi3_pkg::Q_BITS+2:0]                          o_den,
    output logic [mi3_pkg::N_ELEM-1:0]                                    o_neg,
    output logic                                                          o_zero
);
    import mi3_pkg::*;

    localparam int CW  = 2 * DW + 1;
    localparam int PW  = 2 * DW + 1;
    localparam int DTW = 3 * DW + 2;
    localparam int NW  = 3 * DW + 2 * FB + Q_BITS + 3;

    logic [N_COL-1:0][PW-1:0]  r_pl;
    logic [N_COL-1:0][PW-1:0]  r_ph;
    logic [N_ELEM-1:0][CW-1:0] r_cof3;
    logic [N_ELEM-1:0][CW-1:0] r_cof4;
    logic signed [DTW-1:0]     r_det;
    logic signed [DTW-1:0]     n_det;
    logic [N_ELEM-1:0][NW-1:0] r_num;
    logic [N_ELEM-1:0][NW-1:0] n_num;
    logic [NW-1:0]             r_den;
    logic [NW-1:0]             n_den;
    logic [N_ELEM-1:0]         r_neg;
    logic [N_ELEM-1:0]         n_neg;
    logic                      r_zero;
    logic [DTW-1:0]            w_dmag;
    logic                      w_dneg;
    logic                      r_v3;
    logic                      r_v4;
    logic                      r_v5;
    logic                      w_en3;
    logic                      w_en4;
    logic                      w_en5;

    assign w_en5 = !r_v5 || i_dn_ready;
    assign w_en4 = !r_v4 || w_en5;
    assign w_en3 = !r_v3 || w_en4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (w_en3) r_v3 <= i_up_valid;
            if (w_en4) r_v4 <= r_v3;
            if (w_en5) r_v5 <= r_v4;
        end
    end

    always_comb begin
        n_det = '0;
        for (int k = 0; k < N_COL; k++) begin
            n_det = n_det + (DTW'($signed(r_ph[k])) <<< DW) + DTW'($signed(r_pl[k]));
        end
    end

    assign w_dneg = r_det[DTW-1];
    assign w_dmag = w_dneg ? DTW'(-r_det) : DTW'(r_det);

    always_comb begin
        logic [CW-1:0] cmag;
        logic          cneg;
        n_den = NW'(w_dmag) << 1;
        for (int i = 0; i < N_ELEM; i++) begin
            cneg     = r_cof4[i][CW-1];
            cmag     = cneg ? CW'(-r_cof4[i]) : r_cof4[i];
            n_num[i] = (NW'(cmag) << (2 * FB + 1)) + NW'(w_dmag);
            n_neg[i] = cneg ^ w_dneg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en3) begin
            for (int k = 0; k < N_COL; k++) begin
                r_pl[k] <= PW'($signed(i_col[k]) * $signed({1'b0, i_cof[k][DW-1:0]}));
                r_ph[k] <= PW'($signed(i_col[k]) * $signed(i_cof[k][CW-1:DW]));
            end
            r_cof3 <= i_cof;
        end
        if (w_en4) begin
            r_det  <= n_det;
            r_cof4 <= r_cof3;
        end
        if (w_en5) begin
            r_num  <= n_num;
            r_den  <= n_den;
            r_neg  <= n_neg;
            r_zero <= (r_det == '0);
        end
    end

    assign o_up_ready = w_en3;
    assign o_dn_valid = r_v5;
    assign o_num      = r_num;
    assign o_den      = r_den;
    assign o_neg      = r_neg;
    assign o_zero     = r_zero;

endmodule

FILE: src/mi3_div.sv
// mi3_div: restoring divider, one quotient bit per stage, nine lanes
// a first stage checks quotient overflow, the denominator is shared by lanes
// depends on mi3_pkg
module mi3_div #(
    parameter int DW = mi3_pkg::DATA_WIDTH_DEF,
    parameter int FB = mi3_pkg::FRAC_BITS_DEF
) (
    input  logic                                                          i_clk,
    input  logic                                                          i_rst_n,
    input  logic                                                          i_up_valid,
    output logic                                                          o_up_ready,
    input  logic [mi3_pkg::N_ELEM-1:0][3*DW+2*FB+mi3_pkg::Q_BITS+2:0]     i_num,
    input  logic [3*DW+2*FB+mi3_pkg::Q_BITS+2:0]                          i_den,
    input  logic [mi3_pkg::N_ELEM-1:0]                                    i_neg,
    input  logic                                                          i_zero,
    output logic                                                          o_dn_valid,
    input  logic                                                          i_dn_ready,
    output logic [mi3_pkg::N_ELEM-1:0][mi3_pkg::Q_BITS-1:0]               o_quo,
    output logic [mi3_pkg::N_ELEM-1:0]                                    o_ovf,
    output logic [mi3_pkg::N_ELEM-1:0]                                    o_neg,
    output logic                                                          o_zero
);
    import mi3_pkg::*;

    localparam int NW = 3 * DW + 2 * FB + Q_BITS + 3;
    localparam int NS = Q_BITS + 1;

    logic [N_ELEM-1:0][NW-1:0]     r_rem [NS];
    logic [N_ELEM-1:0][Q_BITS-1:0] r_quo [NS];
    logic [N_ELEM-1:0]             r_ovf [NS];
    logic [N_ELEM-1:0]             r_neg [NS];
    logic [NW-1:0]                 r_den [NS];
    logic                          r_zero [NS];
    logic                          r_v [NS];
    wire  [NS:0]                   w_en;

    assign w_en[NS] = i_dn_ready;

    for (genvar s = 0; s < NS; s++) begin : g_stage
        logic [N_ELEM-1:0][NW-1:0]     n_rem;
        logic [N_ELEM-1:0][Q_BITS-1:0] n_quo;
        logic [N_ELEM-1:0]             n_ovf;
        logic [N_ELEM-1:0]             n_neg;
        logic [NW-1:0]                 n_den;
        logic                          n_zero;
        logic                          n_v;

        assign w_en[s] = !r_v[s] || w_en[s+1];

        if (s == 0) begin : g_first
            always_comb begin
                n_v    = i_up_valid;
                n_den  = i_den;
                n_neg  = i_neg;
                n_zero = i_zero;
                n_rem  = i_num;
                n_quo  = '0;
                for (int i = 0; i < N_ELEM; i++) begin
                    n_ovf[i] = (i_num[i] >= (i_den << Q_BITS));
                end
            end
        end else begin : g_bit
            localparam int K = Q_BITS - s;
            always_comb begin
                logic [NW-1:0] t;
                t      = r_den[s-1] << K;
                n_v    = r_v[s-1];
                n_den  = r_den[s-1];
                n_neg  = r_neg[s-1];
                n_zero = r_zero[s-1];
                n_ovf  = r_ovf[s-1];
                n_rem  = r_rem[s-1];
                n_quo  = r_quo[s-1];
                for (int i = 0; i < N_ELEM; i++) begin
                    if (r_rem[s-1][i] >= t) begin
                        n_rem[i]    = r_rem[s-1][i] - t;
                        n_quo[i][K] = 1'b1;
                    end
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else if (w_en[s]) begin
                r_v[s] <= n_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en[s]) begin
                r_rem[s]  <= n_rem;
                r_quo[s]  <= n_quo;
                r_ovf[s]  <= n_ovf;
                r_neg[s]  <= n_neg;
                r_den[s]  <= n_den;
                r_zero[s] <= n_zero;
            end
        end
    end

    assign o_up_ready = w_en[0];
    assign o_dn_valid = r_v[NS-1];
    assign o_quo      = r_quo[NS-1];
    assign o_ovf      = r_ovf[NS-1];
    assign o_neg      = r_neg[NS-1];
    assign o_zero     = r_zero[NS-1];

endmodule

FILE: src/mi3_out.sv
// mi3_out: sign, saturation and singular override, then the output register
// holds one result beat until the consumer takes it
// depends on mi3_pkg
module mi3_out #(
    parameter int DW = mi3_pkg::DATA_WIDTH_DEF
) (
    input  logic                                             i_clk,
    input  logic                                             i_rst_n,
    input  logic                                             i_up_valid,
    output logic                                             o_up_ready,
    input  logic [mi3_pkg::N_ELEM-1:0][mi3_pkg::Q_BITS-1:0]  i_quo,
    input  logic [mi3_pkg::N_ELEM-1:0]                       i_ovf,
    input  logic [mi3_pkg::N_ELEM-1:0]                       i_neg,
    input  logic                                             i_zero,
    output logic                                             o_dn_valid,
    input  logic                                             i_dn_ready,
    output logic [mi3_pkg::N_ELEM-1:0][DW-1:0]               o_b,
    output logic                                             o_singular,
    output logic                                             o_saturated
);
    import mi3_pkg::*;

    logic [N_ELEM-1:0][DW-1:0] r_b;
    logic [N_ELEM-1:0][DW-1:0] n_b;
    logic                      r_sing;
    logic                      r_sat;
    logic                      n_sat;
    logic                      r_v;
    logic                      w_en;
    logic                      w_bound;

    assign w_en = !r_v || i_dn_ready;

    always_comb begin
        logic [Q_BITS-1:0] mag;
        logic [Q_BITS-1:0] lim;
        logic [Q_BITS-1:0] val;
        logic              ng;
        logic              clip;
        n_sat = 1'b0;
        for (int i = 0; i < N_ELEM; i++) begin
            mag    = i_quo[i];
            ng     = i_neg[i] && (mag[MAG_BITS-1:0] != '0);
            lim    = (Q_BITS'(1) << (DW - 1)) - (ng ? Q_BITS'(0) : Q_BITS'(1));
            clip   = i_ovf[i] || (mag > lim);
            val    = clip ? lim : mag;
            val    = ng ? Q_BITS'(-val) : val;
            n_b[i] = val[DW-1:0];
            n_sat  = n_sat || clip;
        end
        if (i_zero) begin
            n_b   = '0;
            n_sat = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (w_en) begin
            r_v <= i_up_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_b    <= n_b;
            r_sing <= i_zero;
            r_sat  <= n_sat;
        end
    end

    always_comb begin
        w_bound = 1'b0;
        for (int i = 0; i < N_ELEM; i++) begin
            w_bound = w_bound || (r_b[i] == {1'b0, {(DW-1){1'b1}}})
                              || (r_b[i] == {1'b1, {(DW-1){1'b0}}});
        end
    end

    assign o_up_ready  = w_en;
    assign o_dn_valid  = r_v;
    assign o_b         = r_b;
    assign o_singular  = r_sing;
    assign o_saturated = r_sat;

    a_sing_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v && r_sing |-> (r_b == '0) && !r_sat)
        else $error("singular beat with nonzero elements or saturation");

    a_sat_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v && r_sat |-> w_bound)
        else $error("saturated beat without a clipped element");

    a_take_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_up_valid && w_en |=> r_v)
        else $error("accepted beat lost at output register");

endmodule

FILE: src/matrix3x3_inverse_unit.sv
// matrix3x3_inverse_unit: pipelined 3x3 inverse by adjugate over determinant
// stages from input beat to result beat: 2 cofactor, 3 determinant, 97 divider,
// 1 output register; throughput one matrix per cycle unless the output stalls,
// set by the one-bit-per-stage restoring divider; idle stages are refilled
// under a stalled output. synchronous active-low reset clears all valid bits.
// depends on mi3_pkg, mi3_adj, mi3_det, mi3_div, mi3_out
module matrix3x3_inverse_unit #(
    parameter int DATA_WIDTH = mi3_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = mi3_pkg::FRAC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic signed [DATA_WIDTH-1:0] i_a00,
    input  logic signed [DATA_WIDTH-1:0] i_a01,
    input  logic signed [DATA_WIDTH-1:0] i_a02,
    input  logic signed [DATA_WIDTH-1:0] i_a10,
    input  logic signed [DATA_WIDTH-1:0] i_a11,
    input  logic signed [DATA_WIDTH-1:0] i_a12,
    input  logic signed [DATA_WIDTH-1:0] i_a20,
    input  logic signed [DATA_WIDTH-1:0] i_a21,
    input  logic signed [DATA_WIDTH-1:0] i_a22,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic signed [DATA_WIDTH-1:0] o_b00,
    output logic signed [DATA_WIDTH-1:0] o_b01,
    output logic signed [DATA_WIDTH-1:0] o_b02,
    output logic signed [DATA_WIDTH-1:0] o_b10,
    output logic signed [DATA_WIDTH-1:0] o_b11,
    output logic signed [DATA_WIDTH-1:0] o_b12,
    output logic signed [DATA_WIDTH-1:0] o_b20,
    output logic signed [DATA_WIDTH-1:0] o_b21,
    output logic signed [DATA_WIDTH-1:0] o_b22,
    output logic                         o_singular,
    output logic                         o_saturated
);
    import mi3_pkg::*;

    localparam int CW = 2 * DATA_WIDTH + 1;
    localparam int NW = 3 * DATA_WIDTH + 2 * FRAC_BITS + Q_BITS + 3;

    logic [N_ELEM-1:0][DATA_WIDTH-1:0] w_m;
    logic [N_ELEM-1:0][CW-1:0]         w_cof;
    logic [N_COL-1:0][DATA_WIDTH-1:0]  w_col;
    logic [N_ELEM-1:0][NW-1:0]         w_num;
    logic [NW-1:0]                     w_den;
    logic [N_ELEM-1:0]                 w_neg_d;
    logic                              w_zero_d;
    logic [N_ELEM-1:0][Q_BITS-1:0]     w_quo;
    logic [N_ELEM-1:0]                 w_ovf;
    logic [N_ELEM-1:0]                 w_neg_q;
    logic                              w_zero_q;
    logic [N_ELEM-1:0][DATA_WIDTH-1:0] w_b;
    logic                              w_v_adj;
    logic                              w_r_det;
    logic                              w_v_det;
    logic                              w_r_div;
    logic                              w_v_div;
    logic                              w_r_out;

    assign w_m = {i_a22, i_a21, i_a20, i_a12, i_a11, i_a10, i_a02, i_a01, i_a00};

    mi3_adj #(.DW(DATA_WIDTH)) u_adj (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_up_valid (i_valid),
        .o_up_ready (o_ready),
        .i_m        (w_m),
        .o_dn_valid (w_v_adj),
        .i_dn_ready (w_r_det),
        .o_cof      (w_cof),
        .o_col      (w_col)
    );

    mi3_det #(.DW(DATA_WIDTH), .FB(FRAC_BITS)) u_det (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_up_valid (w_v_adj),
        .o_up_ready (w_r_det),
        .i_cof      (w_cof),
        .i_col      (w_col),
        .o_dn_valid (w_v_det),
        .i_dn_ready (w_r_div),
        .o_num      (w_num),
        .o_den      (w_den),
        .o_neg      (w_neg_d),
        .o_zero     (w_zero_d)
    );

    mi3_div #(.DW(DATA_WIDTH), .FB(FRAC_BITS)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_up_valid (w_v_det),
        .o_up_ready (w_r_div),
        .i_num      (w_num),
        .i_den      (w_den),
        .i_neg      (w_neg_d),
        .i_zero     (w_zero_d),
        .o_dn_valid (w_v_div),
        .i_dn_ready (w_r_out),
        .o_quo      (w_quo),
        .o_ovf      (w_ovf),
        .o_neg      (w_neg_q),
        .o_zero     (w_zero_q)
    );

    mi3_out #(.DW(DATA_WIDTH)) u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_up_valid  (w_v_div),
        .o_up_ready  (w_r_out),
        .i_quo       (w_quo),
        .i_ovf       (w_ovf),
        .i_neg       (w_neg_q),
        .i_zero      (w_zero_q),
        .o_dn_valid  (o_valid),
        .i_dn_ready  (i_ready),
        .o_b         (w_b),
        .o_singular  (o_singular),
        .o_saturated (o_saturated)
    );

    assign o_b00 = w_b[0];
    assign o_b01 = w_b[1];
    assign o_b02 = w_b[2];
    assign o_b10 = w_b[3];
    assign o_b11 = w_b[4];
    assign o_b12 = w_b[5];
    assign o_b20 = w_b[6];
    assign o_b21 = w_b[7];
    assign o_b22 = w_b[8];

endmodule
